### hw/rtl/rsi_pkg.sv
package rsi_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned RADIX_W     = 6;
  localparam int unsigned DIGIT_W     = 6;
  localparam int unsigned RESULT_W    = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

  typedef enum logic [2:0] {
    KIND_TERM,
    KIND_SPACE,
    KIND_PLUS,
    KIND_MINUS,
    KIND_DIGIT,
    KIND_OTHER
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [DIGIT_W-1:0]  digit;
  } token_t;

endpackage

### hw/rtl/rsi_char_if.sv
interface rsi_char_if;
  import rsi_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

### hw/rtl/rsi_result_if.sv
interface rsi_result_if;
  import rsi_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic signed [RESULT_W-1:0] value;

  modport source (output valid, output ok, output value, input ready);
  modport sink (input valid, input ok, input value, output ready);
endinterface

### hw/rtl/radix_string_to_integer.sv
// Parses a signed integer from a byte stream, one byte per item, in the base held by
// the radix register (2 to 36, reset 10; any other value makes every result fail).
// Leading whitespace is skipped, one sign is taken, then digits 0-9 and A-Z/a-z are
// accumulated until the first byte that is not a digit of the base; later bytes are
// ignored until the zero byte, which yields one result item (ok, value) and clears
// the parse. The value wraps modulo 2^VALUE_WIDTH, is sign-extended or cut to 32 bits,
// and is 0 when ok is 0. The block takes one byte per cycle while the queue has room:
// the front classifies a byte in the cycle it arrives, a two-entry queue decouples it
// from the back, whose single multiply-add per cycle sets the rate. A result waits in
// an output register; while it stalls, the next terminator and the bytes behind it wait.
// Write the radix only while no string is in flight.
module radix_string_to_integer #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rsi_char_if.sink                    char_i,
  rsi_result_if.source                result_o,
  input  logic                        cfg_we_i,
  input  logic [rsi_pkg::RADIX_W-1:0] cfg_wdata_i
);
  import rsi_pkg::*;

  logic [RADIX_W-1:0] radix_q;
  token_t             front_tok;
  token_t             queue_tok;
  logic               queue_full;
  logic               queue_empty;
  logic               queue_pop;

  // radix register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  // front: classify the incoming byte
  rsi_front u_front (
    .char_code_i (char_i.char_code),
    .token_o     (front_tok)
  );

  // byte is accepted whenever the queue has room
  assign char_i.ready = !queue_full;

  rsi_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (char_i.valid),
    .push_data_i (front_tok),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .empty_o     (queue_empty),
    .pop_data_o  (queue_tok)
  );

  // back: parse state, multiply-add and the result register
  rsi_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .radix_i     (radix_q),
    .tok_valid_i (!queue_empty),
    .tok_i       (queue_tok),
    .tok_pop_o   (queue_pop),
    .result_o    (result_o)
  );

endmodule

### hw/rtl/rsi_front.sv
module rsi_front (
  input  logic [rsi_pkg::CHAR_W-1:0] char_code_i,
  output rsi_pkg::token_t            token_o
);
  import rsi_pkg::*;

  logic [CHAR_W-1:0] c;

  assign c = char_code_i;

  // byte classification, digit value where there is one
  always_comb begin
    token_o.kind  = KIND_OTHER;
    token_o.digit = '0;
    if (c == CH_NUL) begin
      token_o.kind = KIND_TERM;
    end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF ||
                 c == CH_CR || c == CH_FF || c == CH_VT) begin
      token_o.kind = KIND_SPACE;
    end else if (c == CH_PLUS) begin
      token_o.kind = KIND_PLUS;
    end else if (c == CH_MINUS) begin
      token_o.kind = KIND_MINUS;
    end else if (c >= CH_0 && c <= CH_9) begin
      token_o.kind  = KIND_DIGIT;
      token_o.digit = DIGIT_W'(c - CH_0);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      token_o.kind  = KIND_DIGIT;
      token_o.digit = DIGIT_W'(c - CH_UA + 8'd10);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      token_o.kind  = KIND_DIGIT;
      token_o.digit = DIGIT_W'(c - CH_LA + 8'd10);
    end
  end

endmodule

### hw/rtl/rsi_queue.sv
module rsi_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rsi_pkg::token_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output rsi_pkg::token_t pop_data_o
);
  import rsi_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  token_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hw/rtl/rsi_back.sv
module rsi_back #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [rsi_pkg::RADIX_W-1:0] radix_i,
  input  logic                        tok_valid_i,
  input  rsi_pkg::token_t             tok_i,
  output logic                        tok_pop_o,
  rsi_result_if.source                result_o
);
  import rsi_pkg::*;

  localparam logic [1:0] PH_SPACE  = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  logic [1:0]             phase_q, phase_d;
  logic                   neg_q, neg_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic                   seen_q, seen_d;

  logic                   res_valid_q, res_valid_d;
  logic                   res_ok_q, res_ok_d;
  logic [RESULT_W-1:0]    res_value_q, res_value_d;

  logic                   is_term;
  logic                   digit_ok;
  logic                   radix_ok;
  logic                   result_ok;
  logic [VALUE_WIDTH-1:0] mac;
  logic [VALUE_WIDTH-1:0] signed_acc;

  assign is_term   = (tok_i.kind == KIND_TERM);
  assign digit_ok  = (tok_i.kind == KIND_DIGIT) && (tok_i.digit < radix_i);
  assign radix_ok  = (radix_i >= RADIX_MIN) && (radix_i <= RADIX_MAX);
  assign result_ok = seen_q && radix_ok;

  // one multiply-add per digit, wrapping at the value width
  assign mac = acc_q * {{(VALUE_WIDTH-RADIX_W){1'b0}}, radix_i}
             + {{(VALUE_WIDTH-DIGIT_W){1'b0}}, tok_i.digit};

  assign signed_acc = neg_q ? (~acc_q + 1'b1) : acc_q;

  // a terminator needs the output slot, anything else drains freely
  assign tok_pop_o = tok_valid_i && (!is_term || !res_valid_q || result_o.ready);

  always_comb begin
    phase_d     = phase_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    seen_d      = seen_q;
    res_valid_d = res_valid_q && !result_o.ready;
    res_ok_d    = res_ok_q;
    res_value_d = res_value_q;
    if (tok_pop_o) begin
      if (is_term) begin
        res_valid_d = 1'b1;
        res_ok_d    = result_ok;
        res_value_d = result_ok ? RESULT_W'(signed'(signed_acc)) : '0;
        phase_d     = PH_SPACE;
        neg_d       = 1'b0;
        acc_d       = '0;
        seen_d      = 1'b0;
      end else begin
        case (phase_q)
          PH_SPACE: begin
            if (tok_i.kind == KIND_PLUS || tok_i.kind == KIND_MINUS) begin
              phase_d = PH_DIGITS;
              neg_d   = (tok_i.kind == KIND_MINUS);
            end else if (tok_i.kind != KIND_SPACE) begin
              if (digit_ok) begin
                phase_d = PH_DIGITS;
                acc_d   = mac;
                seen_d  = 1'b1;
              end else begin
                phase_d = PH_DONE;
              end
            end
          end
          PH_DIGITS: begin
            if (digit_ok) begin
              acc_d  = mac;
              seen_d = 1'b1;
            end else begin
              phase_d = PH_DONE;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SPACE;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      seen_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      acc_q       <= acc_d;
      seen_q      <= seen_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_ok_q    <= res_ok_d;
    res_value_q <= res_value_d;
  end

  assign result_o.valid = res_valid_q;
  assign result_o.ok    = res_ok_q;
  assign result_o.value = signed'(res_value_q);

endmodule

### tb/tb.sv
module tb;
  import rsi_pkg::*;

  // one parsed string as it leaves the block
  typedef struct packed {
    logic                       ok;
    logic signed [RESULT_W-1:0] value;
  } parse_res_t;

  // where the scan of the current string stands
  typedef enum logic [1:0] {
    SCAN_BLANKS,
    SCAN_DIGITS,
    SCAN_DONE
  } scan_e;

  // hand-written strings: radix, byte count, bytes (last byte in the low bits,
  // terminator added by the loop) and, where obvious, the result typed in
  typedef struct packed {
    logic [RADIX_W-1:0]         radix;
    logic [3:0]                 len;
    logic [55:0]                text;
    logic                       typed;
    logic                       ok;
    logic signed [RESULT_W-1:0] value;
  } probe_t;

  localparam probe_t PROBES [8] = '{
    // empty string straight after reset
    '{RADIX_RESET, 4'd0, 56'h0,            1'b1, 1'b0, 32'sd0},
    // vertical tab, form feed, tab, then a negative number
    '{RADIX_RESET, 4'd5, 56'h0B0C092D37,   1'b1, 1'b1, -32'sd7},
    // '2' is no binary digit, so the scan stops after the '1'
    '{RADIX_MIN,   4'd2, 56'h3132,         1'b1, 1'b1, 32'sd1},
    // six base-36 letters in both cases run past 2^31 and wrap
    '{RADIX_MAX,   4'd6, 56'h5A7A7A7A7A7A, 1'b0, 1'b0, 32'sd0},
    // cr, lf, plus then minus: the second sign ends the digits
    '{6'd16,       4'd4, 56'h0D0A2B2D,     1'b1, 1'b0, 32'sd0},
    // blank after the sign is no longer skipped
    '{6'd16,       4'd3, 56'h2D2035,       1'b1, 1'b0, 32'sd0},
    // radix zero: no byte counts as a digit and the result fails
    '{6'd0,        4'd1, 56'h31,           1'b1, 1'b0, 32'sd0},
    // top radix value with the top byte value
    '{6'd63,       4'd1, 56'hFF,           1'b1, 1'b0, 32'sd0}
  };

  localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int RANDOM_BYTES = 480;  // random part, in input items
  localparam int DRAIN_CYCLES = 8;    // queue plus output register, with margin

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [RADIX_W-1:0] cfg_wdata;

  rsi_char_if   char_bus ();
  rsi_result_if result_bus ();

  radix_string_to_integer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .char_i      (char_bus),
    .result_o    (result_bus),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #10 clk = ~clk;

  // predictor state, mirrors the block between strings
  logic [RADIX_W-1:0]  radix_now;
  scan_e               scan;
  logic                neg_sign;
  logic [RESULT_W-1:0] acc_word;
  logic                any_digit;

  // results still owed by the block, oldest first
  parse_res_t parsed_q [$];

  int errors        = 0;
  int bytes_sent    = 0;
  int strings_done  = 0;
  int results_seen  = 0;
  int radix_writes  = 0;
  int holds_asked   = 0;
  bit no_idle       = 1'b0;

  function automatic logic [6:0] char_digit(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return 7'(c - CH_0);
    if (c >= CH_UA && c <= CH_UZ) return 7'(c - CH_UA + 8'd10);
    if (c >= CH_LA && c <= CH_LZ) return 7'(c - CH_LA + 8'd10);
    return 7'd64;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
           c == CH_FF || c == CH_VT;
  endfunction

  function automatic void clear_scan();
    scan      = SCAN_BLANKS;
    neg_sign  = 1'b0;
    acc_word  = '0;
    any_digit = 1'b0;
  endfunction

  // a byte in the digit phase: accumulate or stop for good
  function automatic void absorb_digit(input logic [7:0] c);
    logic [6:0] d;
    d = char_digit(c);
    if (d < {1'b0, radix_now}) begin
      acc_word  = acc_word * RESULT_W'(radix_now) + RESULT_W'(d);
      any_digit = 1'b1;
    end else begin
      scan = SCAN_DONE;
    end
  endfunction

  // advances the predictor by one byte; returns 1 with the result on a terminator
  function automatic bit scan_char(input logic [7:0] c, output parse_res_t res);
    res = '0;
    if (c == CH_NUL) begin
      res.ok    = any_digit && radix_now >= RADIX_MIN && radix_now <= RADIX_MAX;
      res.value = !res.ok ? '0 : neg_sign ? -acc_word : acc_word;
      clear_scan();
      return 1'b1;
    end
    case (scan)
      SCAN_BLANKS: begin
        if (!is_blank(c)) begin
          scan = SCAN_DIGITS;
          if (c == CH_PLUS || c == CH_MINUS) begin
            neg_sign = (c == CH_MINUS);
          end else begin
            absorb_digit(c);
          end
        end
      end
      SCAN_DIGITS: begin
        absorb_digit(c);
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // sender gap: mostly none or short, now and then long, none in a burst
  function automatic int idle_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  // digit value to a character, letters in either case
  function automatic logic [7:0] digit_char(input int unsigned d);
    if (d < 10) return CH_0 + 8'(d);
    return $urandom_range(0, 1) ? CH_UA + 8'(d - 10) : CH_LA + 8'(d - 10);
  endfunction

  function automatic logic [RADIX_W-1:0] pick_radix();
    case ($urandom_range(0, 11))
      0: return RADIX_MIN;
      1: return RADIX_MAX;
      2, 3: return RADIX_RESET;
      4: return 6'd16;
      5: return 6'd8;
      6, 7: return RADIX_W'($urandom_range(2, 36));
      8: return RADIX_W'($urandom_range(37, 63));
      9: return 6'd63;
      default: return RADIX_W'($urandom_range(0, 1));
    endcase
  endfunction

  // offer one byte, wait for the handshake, then predict
  task automatic push_char(input logic [7:0] c, input bit typed, input parse_res_t typed_res);
    int gap;
    parse_res_t got;
    gap = idle_gap();
    if (gap > 0) begin
      char_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= c;
    do @(posedge clk); while (!char_bus.ready);
    bytes_sent++;
    if (scan_char(c, got)) begin
      parsed_q.push_back(typed ? typed_res : got);
      strings_done++;
    end
  endtask

  // radix change only once the block is empty: sender stops, results drain,
  // then a few more cycles for anything still inside
  task automatic set_radix(input logic [RADIX_W-1:0] r);
    char_bus.valid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
    radix_now = r;
    radix_writes++;
  endtask

  // random string: mostly blanks, sign, digits of the radix and junk after,
  // some pure noise, some with a blank or second sign after the sign
  task automatic send_random_string();
    logic [7:0] text [$];
    int r;
    int n;
    int top;
    top = (radix_now >= RADIX_MIN && radix_now <= RADIX_MAX) ? int'(radix_now) - 1 : 35;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      n = $urandom_range(0, 6);
      repeat (n) text.push_back(8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) text.push_back(blank_char());
      case ($urandom_range(0, 2))
        1: text.push_back(CH_PLUS);
        2: text.push_back(CH_MINUS);
        default: ;
      endcase
      if (r < 20) begin
        text.push_back($urandom_range(0, 1) ? blank_char() :
                       $urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      end
      n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 16);
      repeat (n) text.push_back(digit_char($urandom_range(0, top)));
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(1, 255)));
      end
    end
    foreach (text[i]) push_char(text[i], 1'b0, '0);
    push_char(CH_NUL, 1'b0, '0);
  endtask

  // stimulus: reset, hand-written strings, then random strings
  initial begin : stimulus
    int k;
    int start;
    int str_count;
    parse_res_t typed_res;
    rst_n              = 1'b0;
    char_bus.valid     = 1'b0;
    char_bus.char_code = '0;
    cfg_we             = 1'b0;
    cfg_wdata          = RADIX_RESET;
    radix_now          = RADIX_RESET;
    clear_scan();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hand-written part, radix written wherever the row asks for another one
    foreach (PROBES[i]) begin
      if (PROBES[i].radix != radix_now) set_radix(PROBES[i].radix);
      for (k = 0; k < PROBES[i].len; k++) begin
        push_char(PROBES[i].text[8*(PROBES[i].len-1-k) +: 8], 1'b0, '0);
      end
      typed_res.ok    = PROBES[i].ok;
      typed_res.value = PROBES[i].value;
      push_char(CH_NUL, PROBES[i].typed, typed_res);
    end

    // random part, with radix changes, burst stretches and one long hold-off
    start     = bytes_sent;
    str_count = 0;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if (str_count % 8 == 0) set_radix(pick_radix());
      if (str_count % 11 == 3) no_idle = !no_idle;
      if (str_count == 30) begin
        // receiver holds off while short strings keep coming: the block fills
        holds_asked++;
        no_idle = 1'b1;
        repeat (12) begin
          push_char(digit_char(0), 1'b0, '0);
          push_char(CH_NUL, 1'b0, '0);
        end
        no_idle = 1'b0;
      end
      send_random_string();
      str_count++;
    end

    // drain, then a few cycles for any stray result item
    char_bus.valid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (4 * DRAIN_CYCLES) @(posedge clk);

    $display("%0d strings in %0d bytes over %0d radix writes, %0d results checked",
             strings_done, bytes_sent, radix_writes, results_seen);
    $display("includes blanks, signs, wrap-around, invalid radix and a %0d-cycle hold-off",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("PASS radix_string_to_integer");
    end else begin
      $display("FAIL radix_string_to_integer");
    end
    $finish;
  end

  // result side: random stalls, calm stretches, the long hold-off, and the check
  initial begin : result_sink
    int stall_left;
    int calm_left;
    int holds_served;
    int r;
    parse_res_t want;
    stall_left       = 0;
    calm_left        = 0;
    holds_served     = 0;
    result_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (result_bus.valid && result_bus.ready) begin
        results_seen++;
        if (parsed_q.size() == 0) begin
          $error("result item with nothing expected: ok %0b value %0d",
                 result_bus.ok, result_bus.value);
          errors++;
        end else begin
          want = parsed_q.pop_front();
          if (result_bus.ok !== want.ok) begin
            $error("ok: expected %0b, got %0b", want.ok, result_bus.ok);
            errors++;
          end
          if (result_bus.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, result_bus.value);
            errors++;
          end
        end
      end
      if (holds_served != holds_asked) begin
        holds_served++;
        stall_left       = HOLD_CYCLES;
        result_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        result_bus.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 67) begin
          result_bus.ready <= 1'b1;
        end else if (r < 72) begin
          calm_left        = $urandom_range(30, 80);
          result_bus.ready <= 1'b1;
        end else begin
          stall_left       = (r < 94) ? $urandom_range(0, 2) : $urandom_range(8, 40);
          result_bus.ready <= 1'b0;
        end
      end
    end
  end

  // hang guard, far above the slowest correct run
  initial begin : watchdog
    #5_000_000;
    $display("FAIL radix_string_to_integer");
    $finish;
  end

endmodule
